[hdl/sexdz_pkg.sv]
package sexdz_pkg;

	// Highest number of ticks recorded in one run
	localparam int unsigned MAX_SAMPLES = 4096;

	// Register indexes on the configuration port
	localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
	localparam logic [2:0] CFG_AMPLITUDE    = 3'd1;
	localparam logic [2:0] CFG_BIAS         = 3'd2;
	localparam logic [2:0] CFG_SAMPLE_COUNT = 3'd3;
	localparam logic [2:0] CFG_DEADBAND     = 3'd4;

	// Input operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Fixed-point constants for building the sine table
	localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef enum logic [1:0] {
		RUN_IDLE   = 2'd0,
		RUN_ACTIVE = 2'd1,
		RUN_DONE   = 2'd2
	} run_state_t;

	typedef struct packed {
		logic        [31:0] phase_step;
		logic        [14:0] amplitude;
		logic signed [15:0] bias;
		logic        [12:0] sample_count;
		logic        [14:0] deadband;
	} cfg_t;

	// Record fields carried alongside the drive computation
	typedef struct packed {
		logic        [31:0] time_stamp;
		logic signed [31:0] speed_a;
		logic signed [31:0] speed_b;
		logic signed [31:0] speed_c;
		logic signed [31:0] speed_d;
		logic        [11:0] index;
		logic               stop;
	} rec_t;

	// Quarter-wave sine value in Q0.15 at table step q, for a full turn of 2^bits steps
	function automatic logic [14:0] quarter_sine(input int unsigned q, input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		x  = (64'(q) * TWO_PI_Q30) >> bits;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		// Horner form of the Taylor series
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

	// Clip to the signed 16-bit range
	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		logic signed [15:0] r;
		if (v > 19'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -19'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[hdl/sexdz_ctrl.sv]
module sexdz_ctrl import sexdz_pkg::*; #(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic                       adv,
	input  logic                       accept,
	input  logic                       operation,
	input  rec_t                       rec_in,
	output cfg_t                       cfg,
	output logic                       valid_s1,
	output logic [SINE_TABLE_BITS-1:0] idx_s1,
	output rec_t                       rec_s1
);

	cfg_t               cfg_q;
	run_state_t         state_q;
	run_state_t         state_d;
	logic        [31:0] phase_q;
	logic        [12:0] ticks_q;
	logic               is_tick;
	logic               limit_hit;
	logic               emit;
	rec_t               rec_d;

	assign cfg = cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data;
				CFG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data[14:0];
				CFG_BIAS:         cfg_q.bias         <= cfg_data[15:0];
				CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data[12:0];
				CFG_DEADBAND:     cfg_q.deadband     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Stop check: count reached or table capacity reached
	assign is_tick   = accept && (operation == OP_TICK);
	assign limit_hit = (ticks_q >= cfg_q.sample_count) ||
	                   (32'(ticks_q) >= 32'(MAX_SAMPLES));

	// Next run state
	always_comb begin
		state_d = state_q;
		case (state_q)
			RUN_IDLE, RUN_DONE: begin
				if (accept && operation == OP_START) begin
					state_d = RUN_ACTIVE;
				end
			end
			RUN_ACTIVE: begin
				if (accept && operation == OP_START) begin
					state_d = RUN_ACTIVE;
				end else if (is_tick && limit_hit) begin
					state_d = RUN_DONE;
				end
			end
			default: state_d = RUN_IDLE;
		endcase
	end

	// A tick while running yields one record
	always_comb begin
		emit = 1'b0;
		case (state_q)
			RUN_ACTIVE: emit = is_tick;
			default:    emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RUN_IDLE;
			phase_q <= '0;
			ticks_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && operation == OP_START) begin
				phase_q <= '0;
				ticks_q <= '0;
			end else if (emit && !limit_hit) begin
				phase_q <= phase_q + cfg_q.phase_step;
				ticks_q <= ticks_q + 13'd1;
			end
		end
	end

	// Record for stage 1; a stop record carries only its flag
	always_comb begin
		rec_d       = rec_in;
		rec_d.index = ticks_q[11:0];
		rec_d.stop  = 1'b0;
		if (limit_hit) begin
			rec_d      = '0;
			rec_d.stop = 1'b1;
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= phase_q[31:32-SINE_TABLE_BITS];
			rec_s1 <= rec_d;
		end
	end

endmodule

[hdl/sexdz_sine.sv]
module sexdz_sine import sexdz_pkg::*; #(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [14:0]                amplitude,
	input  logic                       valid_s1,
	input  logic [SINE_TABLE_BITS-1:0] idx_s1,
	input  rec_t                       rec_s1,
	output logic                       valid_s3,
	output logic signed [31:0]         prod_s3,
	output rec_t                       rec_s3
);

	localparam int unsigned QN = 1 << (SINE_TABLE_BITS - 2);
	localparam logic [SINE_TABLE_BITS-2:0] QN_W = (SINE_TABLE_BITS-1)'(QN);

	logic        [14:0]                rom [QN+1];
	logic        [1:0]                 quad;
	logic        [SINE_TABLE_BITS-2:0] low;
	logic        [SINE_TABLE_BITS-2:0] q;
	logic        [14:0]                mag_s2;
	logic                              neg_s2;
	logic                              valid_s2;
	rec_t                              rec_s2;
	logic signed [16:0]                sine_val;
	logic signed [31:0]                amp_ext;
	logic signed [31:0]                sine_ext;

	// Quarter-wave table, endpoints included
	for (genvar i = 0; i <= QN; i++) begin : g_rom
		assign rom[i] = quarter_sine(i, SINE_TABLE_BITS);
	end

	// Fold the full-turn index onto the quarter wave
	assign quad = idx_s1[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
	assign low  = {1'b0, idx_s1[SINE_TABLE_BITS-3:0]};
	assign q    = quad[0] ? (QN_W - low) : low;

	// Stage 2: table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= rom[q];
			neg_s2 <= quad[1];
			rec_s2 <= rec_s1;
		end
	end

	// Stage 3: amplitude times sine
	assign sine_val = neg_s2 ? -$signed({2'b00, mag_s2}) : $signed({2'b00, mag_s2});
	assign amp_ext  = 32'($signed({1'b0, amplitude}));
	assign sine_ext = 32'(sine_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= amp_ext * sine_ext;
			rec_s3  <= rec_s2;
		end
	end

endmodule

[hdl/sexdz_drive.sv]
module sexdz_drive import sexdz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic signed [15:0] bias,
	input  logic [14:0]        deadband,
	input  logic               valid_s3,
	input  logic signed [31:0] prod_s3,
	input  rec_t               rec_s3,
	output logic               out_valid_q,
	output logic signed [15:0] drive_q,
	output logic signed [15:0] excitation_q,
	output logic               saturated_q,
	output rec_t               rec_q
);

	logic signed [31:0] num;
	logic signed [31:0] floor_v;
	logic signed [17:0] v_d;
	logic signed [17:0] v_s4;
	logic               valid_s4;
	rec_t               rec_s4;
	logic signed [18:0] v_ext;
	logic signed [18:0] dz_ext;
	logic signed [18:0] w;
	logic signed [15:0] drv;

	// Stage 4: bias plus scaled sine, divided by 2^15 toward zero
	assign num     = (32'(bias) <<< 15) + prod_s3;
	assign floor_v = num >>> 15;
	assign v_d     = floor_v[17:0] +
	                 ((num[31] && (num[14:0] != 15'd0)) ? 18'sd1 : 18'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s4   <= v_d;
			rec_s4 <= rec_s3;
		end
	end

	// Dead-zone widening and saturation
	assign v_ext  = 19'(v_s4);
	assign dz_ext = $signed({4'b0000, deadband});

	always_comb begin
		if (v_ext > 19'sd0) begin
			w = v_ext + dz_ext;
		end else if (v_ext < 19'sd0) begin
			w = v_ext - dz_ext;
		end else begin
			w = '0;
		end
	end

	assign drv = sat16(w);

	// Output register; a stop record carries zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_q <= rec_s4;
			if (rec_s4.stop) begin
				drive_q      <= '0;
				excitation_q <= '0;
				saturated_q  <= 1'b0;
			end else begin
				drive_q      <= drv;
				excitation_q <= sat16(v_ext);
				saturated_q  <= (19'(drv) != w);
			end
		end
	end

endmodule

[hdl/sine_excitation_with_dead_zone.sv]
// Open-loop sine excitation for motor frequency-response capture. A start
// transaction (tuser high) clears the phase and the sample count and begins a
// run; it gives no record. Each tick while running gives one record: drive is
// bias + amplitude * sin(phase) truncated toward zero, widened by the dead zone
// and clipped to 16 bits, with the timestamp, the wheel speeds and the sample
// number. After sample_count ticks (at most 4096) the next tick gives a stop
// record (stopped set, all else zero) and further ticks are dropped until the
// next start. The sine comes from a quarter-wave table of
// 2^(SINE_TABLE_BITS-2)+1 entries addressed by the top phase bits. One
// transaction is taken every cycle unless the output is stalled; a record
// passes through five register stages (control, table read, multiply, divide,
// dead zone), and the whole pipeline holds while the output is stalled.
module sine_excitation_with_dead_zone import sexdz_pkg::*; #(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_stamp, wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_speed_d
	input  logic [159:0] s_tdata,
	// operation
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// drive, excitation, record_time, record_speed_a, record_speed_b,
	// record_speed_c, record_speed_d, record_index, zero pad
	output logic [207:0] m_tdata,
	// stopped, saturated
	output logic [1:0]   m_tuser
);

	cfg_t                       cfg;
	logic                       adv;
	logic                       accept;
	rec_t                       rec_in;
	logic                       valid_s1;
	logic [SINE_TABLE_BITS-1:0] idx_s1;
	rec_t                       rec_s1;
	logic                       valid_s3;
	logic signed [31:0]         prod_s3;
	rec_t                       rec_s3;
	logic                       out_valid_q;
	logic signed [15:0]         drive_q;
	logic signed [15:0]         excitation_q;
	logic                       saturated_q;
	rec_t                       rec_q;

	// Pipeline moves whenever the output register is free or being taken
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	always_comb begin
		rec_in            = '0;
		rec_in.time_stamp = s_tdata[31:0];
		rec_in.speed_a    = s_tdata[63:32];
		rec_in.speed_b    = s_tdata[95:64];
		rec_in.speed_c    = s_tdata[127:96];
		rec_in.speed_d    = s_tdata[159:128];
	end

	sexdz_ctrl #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.adv      (adv),
		.accept   (accept),
		.operation(s_tuser[0]),
		.rec_in   (rec_in),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.idx_s1   (idx_s1),
		.rec_s1   (rec_s1)
	);

	sexdz_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.amplitude(cfg.amplitude),
		.valid_s1 (valid_s1),
		.idx_s1   (idx_s1),
		.rec_s1   (rec_s1),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.rec_s3   (rec_s3)
	);

	sexdz_drive u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.bias        (cfg.bias),
		.deadband    (cfg.deadband),
		.valid_s3    (valid_s3),
		.prod_s3     (prod_s3),
		.rec_s3      (rec_s3),
		.out_valid_q (out_valid_q),
		.drive_q     (drive_q),
		.excitation_q(excitation_q),
		.saturated_q (saturated_q),
		.rec_q       (rec_q)
	);

	// Output packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, rec_q.index, rec_q.speed_d, rec_q.speed_c, rec_q.speed_b,
	                   rec_q.speed_a, rec_q.time_stamp, excitation_q, drive_q};
	assign m_tuser  = {saturated_q, rec_q.stop};

endmodule
